// ===== rtl/lsg_pkg.sv =====
`default_nettype none
package lsg_pkg;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   localparam logic [2:0] CSR_CENTER_X        = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y        = 3'd1;
   localparam logic [2:0] CSR_RING_COUNT      = 3'd2;
   localparam logic [2:0] CSR_RINGS_PER_PIXEL = 3'd3;
   localparam logic [2:0] CSR_OUT_BITS        = 3'd4;
   localparam logic [2:0] CSR_BLEND_ALPHA     = 3'd5;

   // word fields that ride along the pipeline
   typedef struct packed {
      logic        act;
      logic [1:0]  chan;
      logic [5:0]  slot;
      logic [15:0] gain;
      logic [15:0] raw;
   } tag_type;

   // interpolation control from the table stage
   typedef struct packed {
      logic       interp;
      logic       beyond;
      logic [7:0] frac;
   } side_type;

   typedef struct packed {
      logic [15:0] out_max;
      logic [8:0]  alpha;
   } blend_cfg_type;

endpackage
`default_nettype wire

// ===== rtl/lsg_dist.sv =====
`default_nettype none
module lsg_dist #(
   parameter int COORD_BITS = 12,
   parameter int PW         = COORD_BITS + 17
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire lsg_pkg::tag_type      in_tag,
   input  wire logic [COORD_BITS-1:0] in_row,
   input  wire logic [COORD_BITS-1:0] in_col,
   input  wire logic [COORD_BITS-1:0] center_x,
   input  wire logic [COORD_BITS-1:0] center_y,
   input  wire logic [23:0]           rpp,
   output logic                       out_valid,
   output lsg_pkg::tag_type           out_tag,
   output logic [PW-1:0]              out_pos
);

   localparam int CB   = COORD_BITS;
   localparam int N    = CB + 5;
   localparam int VW   = 2 * N;
   localparam int REMW = N + 3;

   logic                 s1_valid_ff;
   lsg_pkg::tag_type     s1_tag_ff;
   logic [CB-1:0]        dx_ff;
   logic [CB-1:0]        dy_ff;
   logic                 s2_valid_ff;
   lsg_pkg::tag_type     s2_tag_ff;
   logic [2*CB-1:0]      sqx_ff;
   logic [2*CB-1:0]      sqy_ff;
   logic [2*CB:0]        d2;

   logic                 rt_valid_ff [0:N];
   lsg_pkg::tag_type     rt_tag_ff   [0:N];
   logic [N-1:0]         rt_res_ff   [0:N];
   logic [REMW-1:0]      rt_rem_ff   [0:N];
   logic [VW-1:0]        rt_v_ff     [0:N];

   logic                 pos_valid_ff;
   lsg_pkg::tag_type     pos_tag_ff;
   logic [PW-1:0]        pos_ff;
   logic [N+23:0]        prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rt_valid_ff[0] <= 1'b0;
         pos_valid_ff   <= 1'b0;
      end else if (en) begin
         s1_valid_ff    <= in_valid;
         s2_valid_ff    <= s1_valid_ff;
         rt_valid_ff[0] <= s2_valid_ff;
         pos_valid_ff   <= rt_valid_ff[N];
      end
   end

   assign d2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign prod = {24'd0, rt_res_ff[N]} * {{N{1'b0}}, rpp};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff    <= in_tag;
         dx_ff        <= (in_col >= center_x) ? in_col - center_x : center_x - in_col;
         dy_ff        <= (in_row >= center_y) ? in_row - center_y : center_y - in_row;
         s2_tag_ff    <= s1_tag_ff;
         sqx_ff       <= {{CB{1'b0}}, dx_ff} * {{CB{1'b0}}, dx_ff};
         sqy_ff       <= {{CB{1'b0}}, dy_ff} * {{CB{1'b0}}, dy_ff};
         rt_tag_ff[0] <= s2_tag_ff;
         rt_res_ff[0] <= '0;
         rt_rem_ff[0] <= '0;
         rt_v_ff[0]   <= {1'b0, d2, 8'd0};
         pos_tag_ff   <= rt_tag_ff[N];
         pos_ff       <= prod[N+23:12];
      end
   end

   // one root bit per stage
   for (genvar i = 0; i < N; i++) begin : g_root
      logic [REMW-1:0] rem_sh;
      logic [REMW-1:0] trial;
      logic            ge;

      assign rem_sh = {rt_rem_ff[i][REMW-3:0], rt_v_ff[i][VW-1:VW-2]};
      assign trial  = {1'b0, rt_res_ff[i], 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            rt_valid_ff[i+1] <= rt_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_tag_ff[i+1] <= rt_tag_ff[i];
            rt_v_ff[i+1]   <= {rt_v_ff[i][VW-3:0], 2'b00};
            rt_res_ff[i+1] <= {rt_res_ff[i][N-2:0], ge};
            rt_rem_ff[i+1] <= ge ? rem_sh - trial : rem_sh;
         end
      end
   end

   assign out_valid = pos_valid_ff;
   assign out_tag   = pos_tag_ff;
   assign out_pos   = pos_ff;

endmodule
`default_nettype wire

// ===== rtl/lsg_table.sv =====
`default_nettype none
module lsg_table #(
   parameter int MAX_RINGS = 64,
   parameter int CHANNELS  = 4,
   parameter int PW        = 29
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire lsg_pkg::tag_type in_tag,
   input  wire logic [PW-1:0]    in_pos,
   input  wire logic [6:0]       ring_count,
   output logic                  out_valid,
   output lsg_pkg::tag_type      out_tag,
   output lsg_pkg::side_type     out_side,
   output logic [15:0]           out_lo,
   output logic [15:0]           out_hi
);

   localparam int LW    = $clog2(MAX_RINGS);
   localparam int KW    = PW - 8;
   localparam int HALF  = MAX_RINGS / 2 + 1;
   localparam int DEPTH = CHANNELS * HALF;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // entries with even ring index in one bank, odd in the other
   logic [15:0] mem_even [0:DEPTH-1];
   logic [15:0] mem_odd  [0:DEPTH-1];

   logic [8:0]          rc;
   logic [LW-1:0]       last;
   logic [KW-1:0]       k;
   logic                interp;
   logic                beyond;
   logic [LW-1:0]       a;
   logic [2:0]          bank;
   logic [AW-1:0]       rd_even;
   logic [AW-1:0]       rd_odd;
   logic [AW-1:0]       wr_addr;
   logic                wr_ok;
   logic                we_even;
   logic                we_odd;

   logic                valid_ff;
   lsg_pkg::tag_type    tag_ff;
   lsg_pkg::side_type   side_ff;
   logic                a0_ff;
   logic [15:0]         even_q_ff;
   logic [15:0]         odd_q_ff;

   always_comb begin
      rc = {2'b00, ring_count};
      if (rc == 9'd0) begin
         rc = 9'd1;
      end
      if (rc > 9'(MAX_RINGS)) begin
         rc = 9'(MAX_RINGS);
      end
   end

   // channel to bank, folded at elaboration
   always_comb begin
      unique case (in_tag.chan)
         2'd0: bank = 3'(0 % CHANNELS);
         2'd1: bank = 3'(1 % CHANNELS);
         2'd2: bank = 3'(2 % CHANNELS);
         2'd3: bank = 3'(3 % CHANNELS);
      endcase
   end

   assign last    = LW'(rc - 9'd1);
   assign k       = in_pos[PW-1:8];
   assign interp  = k < KW'(last);
   assign beyond  = k > KW'(last);
   assign a       = interp ? LW'(k) : last;
   assign rd_even = AW'(int'(bank) * HALF + ((int'(a) + 1) >> 1));
   assign rd_odd  = AW'(int'(bank) * HALF + (int'(a) >> 1));
   assign wr_addr = AW'(int'(bank) * HALF + (int'(in_tag.slot) >> 1));
   assign wr_ok   = int'(in_tag.slot) < MAX_RINGS;
   assign we_even = in_valid && (in_tag.act == lsg_pkg::ACT_LOAD) && wr_ok && !in_tag.slot[0];
   assign we_odd  = in_valid && (in_tag.act == lsg_pkg::ACT_LOAD) && wr_ok && in_tag.slot[0];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we_even) begin
            mem_even[wr_addr] <= in_tag.gain;
         end
         even_q_ff <= mem_even[rd_even];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (we_odd) begin
            mem_odd[wr_addr] <= in_tag.gain;
         end
         odd_q_ff <= mem_odd[rd_odd];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff         <= in_tag;
         side_ff.interp <= interp;
         side_ff.beyond <= beyond;
         side_ff.frac   <= in_pos[7:0];
         a0_ff          <= a[0];
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_side  = side_ff;
   assign out_lo    = a0_ff ? odd_q_ff : even_q_ff;
   assign out_hi    = a0_ff ? even_q_ff : odd_q_ff;

endmodule
`default_nettype wire

// ===== rtl/lsg_blend.sv =====
`default_nettype none
module lsg_blend (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire lsg_pkg::tag_type       in_tag,
   input  wire lsg_pkg::side_type      in_side,
   input  wire logic [15:0]            in_lo,
   input  wire logic [15:0]            in_hi,
   input  wire lsg_pkg::blend_cfg_type cfg,
   output logic                        out_valid,
   output logic [15:0]                 out_value,
   output logic                        out_beyond
);

   logic        b_valid_ff;
   logic        b_act_ff;
   logic        b_beyond_ff;
   logic [15:0] b_raw_ff;
   logic [23:0] b_gain_ff;
   logic [24:0] gain_sum;

   logic        c_valid_ff;
   logic        c_act_ff;
   logic        c_beyond_ff;
   logic [15:0] c_raw_ff;
   logic [19:0] c_gained_ff;
   logic [39:0] gain_prod;

   logic        d_valid_ff;
   logic        d_act_ff;
   logic        d_beyond_ff;
   logic [16:0] d_blend_ff;
   logic [15:0] gained_clip;
   logic [24:0] blend_sum;
   logic [8:0]  inv_alpha;

   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff;
   logic        rsp_beyond_ff;

   assign gain_sum = in_side.interp
      ? ({9'd0, in_lo} * {16'd0, 9'd256 - {1'b0, in_side.frac}})
        + ({9'd0, in_hi} * {17'd0, in_side.frac})
      : {1'b0, in_lo, 8'd0};

   assign gain_prod = {24'd0, b_raw_ff} * {16'd0, b_gain_ff};

   assign inv_alpha   = 9'd256 - cfg.alpha;
   assign gained_clip = (c_gained_ff > {4'd0, cfg.out_max}) ? cfg.out_max : c_gained_ff[15:0];
   assign blend_sum   = ({9'd0, gained_clip} * {16'd0, cfg.alpha})
                      + ({9'd0, c_raw_ff} * {16'd0, inv_alpha});

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff   <= in_valid;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff && (d_act_ff == lsg_pkg::ACT_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_act_ff      <= in_tag.act;
         b_beyond_ff   <= in_side.beyond;
         b_raw_ff      <= in_tag.raw;
         b_gain_ff     <= gain_sum[23:0];
         c_act_ff      <= b_act_ff;
         c_beyond_ff   <= b_beyond_ff;
         c_raw_ff      <= b_raw_ff;
         c_gained_ff   <= gain_prod[39:20];
         d_act_ff      <= c_act_ff;
         d_beyond_ff   <= c_beyond_ff;
         d_blend_ff    <= blend_sum[24:8];
         rsp_value_ff  <= (d_blend_ff > {1'b0, cfg.out_max}) ? cfg.out_max : d_blend_ff[15:0];
         rsp_beyond_ff <= d_beyond_ff;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_value  = rsp_value_ff;
   assign out_beyond = rsp_beyond_ff;

endmodule
`default_nettype wire

// ===== rtl/radial_lens_shading_gain_core.sv =====
`default_nettype none
// channel  direction  ports
// req      in         req_valid/req_ready, action channel row col raw slot gain
// rsp      out        rsp_valid/rsp_ready, corrected_value beyond_rings
// csr      in         csr_valid/csr_ready, csr_index csr_wdata
//
// One word per cycle while no result is held. The square root yields one
// result bit per stage. Gain table: two simple dual-port banks (even/odd
// ring) read together for interpolation. Load words make no result.
// Synchronous reset clears control and registers; the table is not cleared.
// A held result stalls the whole pipeline; csr_ready is always high.
module radial_lens_shading_gain_core #(
   parameter int MAX_RINGS  = 64,
   parameter int COORD_BITS = 12,
   parameter int CHANNELS   = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [1:0]  req_channel,
   input  wire logic [11:0] req_pixel_row,
   input  wire logic [11:0] req_pixel_col,
   input  wire logic [15:0] req_raw_value,
   input  wire logic [5:0]  req_ring_slot,
   input  wire logic [15:0] req_gain_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_corrected_value,
   output logic             rsp_beyond_rings,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam int PW = COORD_BITS + 17;

   logic [11:0] center_x_ff;
   logic [11:0] center_y_ff;
   logic [6:0]  ring_count_ff;
   logic [23:0] rings_per_pixel_ff;
   logic [4:0]  out_bits_ff;
   logic [8:0]  blend_alpha_ff;

   logic                   advance;
   lsg_pkg::tag_type       req_tag;
   lsg_pkg::blend_cfg_type bcfg;
   logic [4:0]             ob;

   logic                   dist_valid;
   lsg_pkg::tag_type       dist_tag;
   logic [PW-1:0]          dist_pos;
   logic                   tab_valid;
   lsg_pkg::tag_type       tab_tag;
   lsg_pkg::side_type      tab_side;
   logic [15:0]            tab_lo;
   logic [15:0]            tab_hi;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff        <= 12'd0;
         center_y_ff        <= 12'd0;
         ring_count_ff      <= 7'd1;
         rings_per_pixel_ff <= 24'd0;
         out_bits_ff        <= 5'd16;
         blend_alpha_ff     <= 9'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            lsg_pkg::CSR_CENTER_X:        center_x_ff        <= csr_wdata[11:0];
            lsg_pkg::CSR_CENTER_Y:        center_y_ff        <= csr_wdata[11:0];
            lsg_pkg::CSR_RING_COUNT:      ring_count_ff      <= csr_wdata[6:0];
            lsg_pkg::CSR_RINGS_PER_PIXEL: rings_per_pixel_ff <= csr_wdata;
            lsg_pkg::CSR_OUT_BITS:        out_bits_ff        <= csr_wdata[4:0];
            lsg_pkg::CSR_BLEND_ALPHA:     blend_alpha_ff     <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ob = out_bits_ff;
      if (ob < 5'd8) begin
         ob = 5'd8;
      end
      if (ob > 5'd16) begin
         ob = 5'd16;
      end
      bcfg.out_max = 16'((17'd1 << ob) - 17'd1);
      bcfg.alpha   = (blend_alpha_ff > 9'd256) ? 9'd256 : blend_alpha_ff;
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign req_tag.act  = req_action;
   assign req_tag.chan = req_channel;
   assign req_tag.slot = req_ring_slot;
   assign req_tag.gain = req_gain_word;
   assign req_tag.raw  = req_raw_value;

   lsg_dist #(
      .COORD_BITS (COORD_BITS),
      .PW         (PW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (req_valid),
      .in_tag    (req_tag),
      .in_row    (COORD_BITS'(req_pixel_row)),
      .in_col    (COORD_BITS'(req_pixel_col)),
      .center_x  (COORD_BITS'(center_x_ff)),
      .center_y  (COORD_BITS'(center_y_ff)),
      .rpp       (rings_per_pixel_ff),
      .out_valid (dist_valid),
      .out_tag   (dist_tag),
      .out_pos   (dist_pos)
   );

   lsg_table #(
      .MAX_RINGS (MAX_RINGS),
      .CHANNELS  (CHANNELS),
      .PW        (PW)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (dist_valid),
      .in_tag     (dist_tag),
      .in_pos     (dist_pos),
      .ring_count (ring_count_ff),
      .out_valid  (tab_valid),
      .out_tag    (tab_tag),
      .out_side   (tab_side),
      .out_lo     (tab_lo),
      .out_hi     (tab_hi)
   );

   lsg_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (tab_valid),
      .in_tag     (tab_tag),
      .in_side    (tab_side),
      .in_lo      (tab_lo),
      .in_hi      (tab_hi),
      .cfg        (bcfg),
      .out_valid  (rsp_valid),
      .out_value  (rsp_corrected_value),
      .out_beyond (rsp_beyond_rings)
   );

endmodule
`default_nettype wire
